/* rtl/bs3d_pkg.sv */
// bs3d_pkg: shared widths, register codes and control types of the 27-point box stencil.
// No dependencies; other files reference it by scoped names or import it.
package bs3d_pkg;

    localparam int XY_W       = 6;
    localparam int POS_W      = XY_W + 1;
    localparam int Z_W        = 12;
    localparam int IDX_W      = 5;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 36;
    localparam int TAPS       = 27;
    localparam int SPAN       = 2*1 + 1;
    localparam int MAX_DEPTH  = 4094;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

/* rtl/bs3d_if.sv */
// bs3d_if: valid/ready channel interfaces for input items, results and register writes.
// Depends on bs3d_pkg for field widths.
interface bs3d_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [bs3d_pkg::IDX_W-1:0]        weight_index;
    logic signed [bs3d_pkg::VAL_W-1:0] value;
    modport source (output valid, kind, weight_index, value, input ready);
    modport sink   (input valid, kind, weight_index, value, output ready);
endinterface

interface bs3d_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bs3d_pkg::SUM_W-1:0] weighted_sum;
    logic [bs3d_pkg::XY_W-1:0]         out_x;
    logic [bs3d_pkg::XY_W-1:0]         out_y;
    logic [bs3d_pkg::Z_W-1:0]          out_z;
    logic                              last;
    modport source (output valid, weighted_sum, out_x, out_y, out_z, last, input ready);
    modport sink   (input valid, weighted_sum, out_x, out_y, out_z, last, output ready);
endinterface

interface bs3d_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bs3d_pkg::CFG_IDX_W-1:0]       index;
    logic [bs3d_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bs3d_hist.sv */
// bs3d_hist: three-plane sample history memory, one write and one registered read port.
// Depends on bs3d_pkg for position widths.
module bs3d_hist #(
    parameter int MAX_PADDED_WIDTH  = 64,
    parameter int MAX_PADDED_HEIGHT = 64,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [1:0]                        i_wslot,
    input  logic [bs3d_pkg::POS_W-1:0]        i_wrow,
    input  logic [bs3d_pkg::POS_W-1:0]        i_wcol,
    input  logic signed [SAMPLE_BITS-1:0]     i_wdata,
    input  logic [1:0]                        i_rslot,
    input  logic [bs3d_pkg::POS_W-1:0]        i_rrow,
    input  logic [bs3d_pkg::POS_W-1:0]        i_rcol,
    output logic signed [SAMPLE_BITS-1:0]     o_rdata
);

    localparam int PLANE  = MAX_PADDED_WIDTH * MAX_PADDED_HEIGHT;
    localparam int DEPTH  = bs3d_pkg::SPAN * PLANE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;

    assign w_waddr = ADDR_W'(i_wslot) * ADDR_W'(PLANE)
                   + ADDR_W'(i_wrow) * ADDR_W'(MAX_PADDED_WIDTH) + ADDR_W'(i_wcol);
    assign w_raddr = ADDR_W'(i_rslot) * ADDR_W'(PLANE)
                   + ADDR_W'(i_rrow) * ADDR_W'(MAX_PADDED_WIDTH) + ADDR_W'(i_rcol);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bs3d_mac.sv */
// bs3d_mac: shared signed multiply-accumulate, product register then accumulator.
// Depends on bs3d_pkg for t_mac_ctl and the result width.
module bs3d_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bs3d_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic signed [bs3d_pkg::VAL_W-1:0]   i_weight,
    output logic                                o_done,
    output logic [bs3d_pkg::SUM_W-1:0]          o_sum
);

    localparam int PROD_W = SAMPLE_BITS + bs3d_pkg::VAL_W;
    localparam int ACC_W  = (PROD_W > bs3d_pkg::SUM_W) ? PROD_W : bs3d_pkg::SUM_W;

    bs3d_pkg::t_mac_ctl        r_pctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [ACC_W-1:0]   w_ext;

    assign w_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_weight;
        if (r_pctl.valid) begin
            r_acc <= r_pctl.first ? w_ext : r_acc + w_ext;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc[bs3d_pkg::SUM_W-1:0];

endmodule

/* rtl/box_stencil_3d_radius1_top.sv */
// box_stencil_3d_radius1_top: 27-point box stencil, sequencer, weight store and grid walk.
// Depends on bs3d_pkg, bs3d_if, bs3d_hist and bs3d_mac.
//
//  channel  dir  beat
//  i_in     in   kind, weight_index, value
//  o_out    out  weighted_sum, out_x, out_y, out_z, last
//  i_cfg    in   index, data (register write)
//
// Weight beats and halo samples are taken while idle and start no window. A sample that closes
// a window is written to history, then its 27 taps are read in turn through the single history
// read port into the shared MAC, followed by pipeline drain and hand-off; no beat is taken meanwhile.
// Reset clears weights, positions and control registers; history needs no clearing pass.
// A finished result waits in the output register while new beats are taken; the
// sequencer only stalls if the next result is ready before the previous one leaves.
module box_stencil_3d_radius1_top #(
    parameter int MAX_PADDED_WIDTH  = 64,
    parameter int MAX_PADDED_HEIGHT = 64,
    parameter int SAMPLE_BITS       = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bs3d_in_if.sink           i_in,
    bs3d_out_if.source        o_out,
    bs3d_cfg_if.sink          i_cfg
);

    localparam int POS_W = bs3d_pkg::POS_W;
    localparam int XY_W  = bs3d_pkg::XY_W;
    localparam int Z_W   = bs3d_pkg::Z_W;
    localparam int W_HI  = (MAX_PADDED_WIDTH - 2 < 63) ? MAX_PADDED_WIDTH - 2 : 63;
    localparam int H_HI  = (MAX_PADDED_HEIGHT - 2 < 63) ? MAX_PADDED_HEIGHT - 2 : 63;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]        r_state;
    logic [XY_W-1:0]   r_iw;
    logic [XY_W-1:0]   r_ih;
    logic [Z_W-1:0]    r_id;
    logic [POS_W-1:0]  r_px;
    logic [POS_W-1:0]  r_py;
    logic [Z_W-1:0]    r_pz;
    logic [1:0]        r_zslot;
    logic signed [bs3d_pkg::VAL_W-1:0] r_weight [bs3d_pkg::TAPS];

    logic [POS_W-1:0]  r_bx;
    logic [POS_W-1:0]  r_by;
    logic [1:0]        r_zs;
    logic [Z_W-1:0]    r_qz;
    logic              r_qlast;
    logic [1:0]        r_tx;
    logic [1:0]        r_ty;
    logic [bs3d_pkg::IDX_W-1:0] r_tap;
    logic signed [bs3d_pkg::VAL_W-1:0] r_wt;
    bs3d_pkg::t_mac_ctl r_c1;
    logic              r_have;

    logic              r_ovalid;
    logic [XY_W-1:0]   r_ox;
    logic [XY_W-1:0]   r_oy;
    logic [Z_W-1:0]    r_oz;
    logic              r_olast;
    logic [bs3d_pkg::SUM_W-1:0] r_osum;

    logic [POS_W-1:0]  w_w;
    logic [POS_W-1:0]  w_h;
    logic [Z_W-1:0]    w_d;
    logic [POS_W-1:0]  w_wl;
    logic [POS_W-1:0]  w_hl;
    logic [Z_W-1:0]    w_dl;
    logic              w_oor;
    logic [POS_W-1:0]  w_ex;
    logic [POS_W-1:0]  w_ey;
    logic [Z_W-1:0]    w_ez;
    logic [1:0]        w_es;
    logic              w_interior;
    logic [POS_W-1:0]  n_px;
    logic [POS_W-1:0]  n_py;
    logic [Z_W-1:0]    n_pz;
    logic [1:0]        n_zslot;
    logic              w_in_acc;
    logic              w_sample;
    logic              w_cfg_acc;
    logic              w_out_free;
    logic              w_mac_done;
    logic [bs3d_pkg::SUM_W-1:0] w_mac_sum;
    logic signed [SAMPLE_BITS-1:0] w_samp;
    logic signed [SAMPLE_BITS-1:0] w_rdata;
    bs3d_pkg::t_mac_ctl w_issue;

    generate
        if (SAMPLE_BITS <= bs3d_pkg::VAL_W) begin : g_narrow
            assign w_samp = i_in.value[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign w_samp = {{(SAMPLE_BITS - bs3d_pkg::VAL_W){i_in.value[bs3d_pkg::VAL_W-1]}},
                             i_in.value};
        end
    endgenerate

    // clamped dimensions and last padded coordinate
    assign w_w = (r_iw == '0) ? POS_W'(1) :
                 (POS_W'(r_iw) > POS_W'(W_HI)) ? POS_W'(W_HI) : POS_W'(r_iw);
    assign w_h = (r_ih == '0) ? POS_W'(1) :
                 (POS_W'(r_ih) > POS_W'(H_HI)) ? POS_W'(H_HI) : POS_W'(r_ih);
    assign w_d = (r_id == '0) ? Z_W'(1) :
                 (r_id > Z_W'(bs3d_pkg::MAX_DEPTH)) ? Z_W'(bs3d_pkg::MAX_DEPTH) : r_id;
    assign w_wl = w_w + POS_W'(1);
    assign w_hl = w_h + POS_W'(1);
    assign w_dl = w_d + Z_W'(1);

    assign w_oor = (r_px > w_wl) || (r_py > w_hl) || (r_pz > w_dl);
    assign w_ex  = w_oor ? '0 : r_px;
    assign w_ey  = w_oor ? '0 : r_py;
    assign w_ez  = w_oor ? '0 : r_pz;
    assign w_es  = w_oor ? '0 : r_zslot;
    assign w_interior = (w_ex >= POS_W'(2)) && (w_ey >= POS_W'(2)) && (w_ez >= Z_W'(2));

    always_comb begin
        n_px    = w_ex + POS_W'(1);
        n_py    = w_ey;
        n_pz    = w_ez;
        n_zslot = w_es;
        if (n_px > w_wl) begin
            n_px = '0;
            n_py = w_ey + POS_W'(1);
            if (n_py > w_hl) begin
                n_py    = '0;
                n_pz    = w_ez + Z_W'(1);
                n_zslot = (w_es == 2'd2) ? 2'd0 : w_es + 2'd1;
                if (n_pz > w_dl) begin
                    n_pz    = '0;
                    n_zslot = 2'd0;
                end
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_sample    = w_in_acc && (i_in.kind == bs3d_pkg::KIND_SAMPLE);
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_ovalid || o_out.ready;

    assign w_issue.valid = (r_state == S_RUN);
    assign w_issue.first = (r_tap == '0);
    assign w_issue.last  = (r_tap == bs3d_pkg::IDX_W'(bs3d_pkg::TAPS - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iw     <= XY_W'(1);
            r_ih     <= XY_W'(1);
            r_id     <= Z_W'(1);
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_zslot  <= '0;
            r_tap    <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_c1     <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < bs3d_pkg::TAPS; i++) begin
                r_weight[i] <= '0;
            end
        end else begin
            r_c1 <= w_issue;
            if (w_mac_done) begin
                r_have <= 1'b1;
            end
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in.kind == bs3d_pkg::KIND_WEIGHT) &&
                        (i_in.weight_index < bs3d_pkg::IDX_W'(bs3d_pkg::TAPS))) begin
                        r_weight[i_in.weight_index] <= i_in.value;
                    end
                    if (w_sample) begin
                        r_px    <= n_px;
                        r_py    <= n_py;
                        r_pz    <= n_pz;
                        r_zslot <= n_zslot;
                        if (w_interior) begin
                            r_state <= S_RUN;
                            r_tap   <= '0;
                            r_tx    <= '0;
                            r_ty    <= '0;
                        end
                    end
                end
                S_RUN: begin
                    r_tap <= r_tap + bs3d_pkg::IDX_W'(1);
                    if (r_tx == 2'd2) begin
                        r_tx <= '0;
                        r_ty <= (r_ty == 2'd2) ? 2'd0 : r_ty + 2'd1;
                    end else begin
                        r_tx <= r_tx + 2'd1;
                    end
                    if (w_issue.last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (r_have && w_out_free) begin
                        r_have   <= 1'b0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_cfg_acc) begin
                unique case (i_cfg.index)
                    bs3d_pkg::CFG_WIDTH:  r_iw <= i_cfg.data[XY_W-1:0];
                    bs3d_pkg::CFG_HEIGHT: r_ih <= i_cfg.data[XY_W-1:0];
                    bs3d_pkg::CFG_DEPTH:  r_id <= i_cfg.data;
                    default: ;
                endcase
                if (i_cfg.index == bs3d_pkg::CFG_WIDTH || i_cfg.index == bs3d_pkg::CFG_HEIGHT ||
                    i_cfg.index == bs3d_pkg::CFG_DEPTH) begin
                    r_px    <= '0;
                    r_py    <= '0;
                    r_pz    <= '0;
                    r_zslot <= '0;
                end
            end
        end
    end

    // payload; output fields change only when a new result is handed off
    always_ff @(posedge i_clk) begin
        r_wt <= r_weight[r_tap];
        if (r_state == S_IDLE && w_sample && w_interior) begin
            r_bx    <= w_ex - POS_W'(2);
            r_by    <= w_ey - POS_W'(2);
            r_zs    <= (w_es == 2'd2) ? 2'd0 : w_es + 2'd1;
            r_qz    <= w_ez - Z_W'(2);
            r_qlast <= (w_ex == w_wl) && (w_ey == w_hl) && (w_ez == w_dl);
        end
        if (r_state == S_RUN && r_tx == 2'd2 && r_ty == 2'd2) begin
            r_zs <= (r_zs == 2'd2) ? 2'd0 : r_zs + 2'd1;
        end
        if (r_state == S_WAIT && r_have && w_out_free) begin
            r_osum  <= w_mac_sum;
            r_ox    <= XY_W'(r_bx);
            r_oy    <= XY_W'(r_by);
            r_oz    <= r_qz;
            r_olast <= r_qlast;
        end
    end

    bs3d_hist #(
        .MAX_PADDED_WIDTH  (MAX_PADDED_WIDTH),
        .MAX_PADDED_HEIGHT (MAX_PADDED_HEIGHT),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_sample),
        .i_wslot (w_es),
        .i_wrow  (w_ey),
        .i_wcol  (w_ex),
        .i_wdata (w_samp),
        .i_rslot (r_zs),
        .i_rrow  (r_by + POS_W'(r_ty)),
        .i_rcol  (r_bx + POS_W'(r_tx)),
        .o_rdata (w_rdata)
    );

    bs3d_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_c1),
        .i_sample (w_rdata),
        .i_weight (r_wt),
        .o_done   (w_mac_done),
        .o_sum    (w_mac_sum)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.weighted_sum = r_osum;
    assign o_out.out_x        = r_ox;
    assign o_out.out_y        = r_oy;
    assign o_out.out_z        = r_oz;
    assign o_out.last         = r_olast;

endmodule

/* tb/bs3d_checker.sv */
// bs3d_checker: scoreboard for the 27-point box stencil; tracks weights, grid position and
// sample planes from the observed beats and checks every result beat in order.
// Depends on bs3d_pkg and the channel interfaces in bs3d_if.
module bs3d_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bs3d_in_if   i_in,
    bs3d_out_if  i_res,
    bs3d_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import bs3d_pkg::*;

    localparam int PAD_W       = 64;
    localparam int PAD_H       = 64;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic signed [SUM_W-1:0] weighted_sum;
        logic [XY_W-1:0]         out_x;
        logic [XY_W-1:0]         out_y;
        logic [Z_W-1:0]          out_z;
        logic                    last;
    } t_point_sum;

    logic signed [VAL_W-1:0] coeffs [TAPS];
    logic signed [VAL_W-1:0] planes [SPAN][PAD_H][PAD_W];
    int unsigned             col, row, plane;
    int unsigned             width_reg, height_reg, depth_reg;
    t_point_sum              sums_due [$];

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            if (o_fail_count < MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    task automatic advance_stencil(input logic kind, input logic [IDX_W-1:0] slot,
                                   input logic signed [VAL_W-1:0] value);
        int unsigned w, h, d, tx, ty, tz;
        longint      acc;
        t_point_sum  sum;
        if (kind == KIND_WEIGHT) begin
            if (slot < TAPS)
                coeffs[slot] = value;
        end else begin
            w = clamp_dim(width_reg, PAD_W - 2);
            h = clamp_dim(height_reg, PAD_H - 2);
            d = clamp_dim(depth_reg, MAX_DEPTH);
            if (col > w + 1 || row > h + 1 || plane > d + 1) begin
                col = 0;
                row = 0;
                plane = 0;
            end
            planes[plane % SPAN][row][col] = value;
            if (col >= 2 && row >= 2 && plane >= 2) begin
                acc = 0;
                for (tz = 0; tz < SPAN; tz++)
                    for (ty = 0; ty < SPAN; ty++)
                        for (tx = 0; tx < SPAN; tx++)
                            acc += longint'(planes[(plane - 2 + tz) % SPAN]
                                                  [row - 2 + ty][col - 2 + tx])
                                   * longint'(coeffs[tx + SPAN * ty + SPAN * SPAN * tz]);
                sum.weighted_sum = acc[SUM_W-1:0];
                sum.out_x = XY_W'(col - 2);
                sum.out_y = XY_W'(row - 2);
                sum.out_z = Z_W'(plane - 2);
                sum.last = (col == w + 1 && row == h + 1 && plane == d + 1);
                sums_due.push_back(sum);
            end
            col++;
            if (col > w + 1) begin
                col = 0;
                row++;
                if (row > h + 1) begin
                    row = 0;
                    plane++;
                    if (plane > d + 1)
                        plane = 0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_point_sum want;
        if (!i_rst_n) begin
            foreach (coeffs[k])
                coeffs[k] = '0;
            col = 0;
            row = 0;
            plane = 0;
            width_reg = 1;
            height_reg = 1;
            depth_reg = 1;
            sums_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (sums_due.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $error("unexpected result beat: x=%0d y=%0d z=%0d sum=%0d",
                               i_res.out_x, i_res.out_y, i_res.out_z, i_res.weighted_sum);
                    o_fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    check_field("weighted_sum", want.weighted_sum, i_res.weighted_sum);
                    check_field("out_x", want.out_x, i_res.out_x);
                    check_field("out_y", want.out_y, i_res.out_y);
                    check_field("out_z", want.out_z, i_res.out_z);
                    check_field("last", want.last, i_res.last);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_WIDTH:  width_reg  = i_cfg.data[XY_W-1:0];
                    CFG_HEIGHT: height_reg = i_cfg.data[XY_W-1:0];
                    CFG_DEPTH:  depth_reg  = i_cfg.data;
                    default: ;
                endcase
                if (i_cfg.index inside {CFG_WIDTH, CFG_HEIGHT, CFG_DEPTH}) begin
                    col = 0;
                    row = 0;
                    plane = 0;
                end
            end
            if (i_in.valid && i_in.ready)
                advance_stencil(i_in.kind, i_in.weight_index, i_in.value);
        end
        o_pending = sums_due.size();
    end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for box_stencil_3d_radius1_top; drives weight and sample beats,
// register writes and output back-pressure; checking lives in bs3d_checker.
// Depends on bs3d_pkg, bs3d_if, bs3d_checker and the RTL.
module tb;
    import bs3d_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bs3d_in_if  in_ch();
    bs3d_out_if out_ch();
    bs3d_cfg_if cfg_ch();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int beats_sent = 0;
    int send_idle_pct = 0;
    int take_stall_pct = 0;
    int unsigned grid_w = 1, grid_h = 1, grid_d = 1;

    box_stencil_3d_radius1_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bs3d_checker i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [IDX_W-1:0] slot,
                             input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.weight_index <= slot;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (kind == KIND_SAMPLE || slot < TAPS)
            beats_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // holds valid high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic configure_grid(input logic [CFG_DATA_W-1:0] wd,
                                  input logic [CFG_DATA_W-1:0] hd,
                                  input logic [CFG_DATA_W-1:0] dd);
        drain_results();
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, hd);
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_DEPTH, dd);
        cfg_ch.valid <= 1'b0;
        grid_w = (wd[XY_W-1:0] == 0) ? 1 : ((wd[XY_W-1:0] > 62) ? 62 : wd[XY_W-1:0]);
        grid_h = (hd[XY_W-1:0] == 0) ? 1 : ((hd[XY_W-1:0] > 62) ? 62 : hd[XY_W-1:0]);
        grid_d = (dd == 0) ? 1 : ((dd > MAX_DEPTH) ? MAX_DEPTH : dd);
    endtask

    task automatic load_coeffs(input logic fixed, input logic [VAL_W-1:0] fixed_value);
        for (int slot = 0; slot < TAPS; slot++)
            send_beat(KIND_WEIGHT, IDX_W'(slot), fixed ? fixed_value : pick_value());
    endtask

    // random streams occasionally slip a weight update in between samples
    task automatic stream_samples(input int unsigned count, input logic fixed,
                                  input logic [VAL_W-1:0] fixed_value);
        for (int unsigned n = 0; n < count; n++) begin
            if (!fixed && $urandom_range(19) == 0)
                send_beat(KIND_WEIGHT, IDX_W'($urandom), pick_value());
            send_beat(KIND_SAMPLE, IDX_W'($urandom), fixed ? fixed_value : pick_value());
        end
    endtask

    task automatic random_grid();
        int unsigned w, h, d, total, count;
        if ($urandom_range(4) != 0) begin
            w = $urandom_range(5);
            h = $urandom_range(5);
            d = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(3);
            configure_grid({6'($urandom), 6'(w)}, {6'($urandom), 6'(h)}, 12'(d));
        end
        if ($urandom_range(5) == 0)
            load_coeffs(1'b0, '0);
        total = (grid_w + 2) * (grid_h + 2) * (grid_d + 2);
        count = ($urandom_range(5) == 0) ? $urandom_range(total) : total;
        if (total > 600)
            count = $urandom_range(80, 20);
        stream_samples(count, 1'b0, '0);
    endtask

    initial begin
        static int phase_goal [4] = '{750, 1400, 1700, 1950};
        static int stall_cfg [4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{25, 25}};
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_WEIGHT;
        in_ch.weight_index <= '0;
        in_ch.value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_WIDTH;
        cfg_ch.data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid is 1x1x1: corner and center taps, two out-of-range slots, then one full window
        send_beat(KIND_WEIGHT, 5'd0, 16'h8000);
        send_beat(KIND_WEIGHT, 5'd26, 16'h7FFF);
        send_beat(KIND_WEIGHT, 5'd13, 16'h4000);
        send_beat(KIND_WEIGHT, 5'd27, 16'h1234);
        send_beat(KIND_WEIGHT, 5'd31, 16'hFFFF);
        stream_samples(27, 1'b0, '0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = stall_cfg[phase][0];
            take_stall_pct = stall_cfg[phase][1];
            case (phase)
                0: begin
                    // widest row via clamp, then largest and smallest sums
                    configure_grid(12'h03F, 12'h000, 12'h001);
                    stream_samples(64 * 3 * 3, 1'b0, '0);
                    configure_grid(12'hFC1, 12'h001, 12'h001);
                    load_coeffs(1'b1, 16'h8000);
                    stream_samples(27, 1'b1, 16'h8000);
                    stream_samples(27, 1'b1, 16'h7FFF);
                end
                1: begin
                    configure_grid(12'h000, 12'hABE, 12'h000);
                    load_coeffs(1'b0, '0);
                    stream_samples(3 * 64 * 3, 1'b0, '0);
                end
                2: begin
                    // deepest grid, cut short; sender holds off until all sums are out
                    configure_grid(12'h001, 12'h001, 12'hFFF);
                    stream_samples(40, 1'b0, '0);
                    drain_results();
                    stream_samples(40, 1'b0, '0);
                end
                default: ;
            endcase
            while (beats_sent < phase_goal[phase])
                random_grid();
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
